// ----- src/drpu_pkg.sv -----
// Shared types, constants and a lookup function for the dead-reckoning position update.
package drpu_pkg;

	// Field widths
	localparam int HEADING_W = 16;
	localparam int ODO_W     = 32;
	localparam int POS_W     = 32;
	localparam int RESID_W   = 14;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 1'b1;

	// Heading in hundredths of a degree
	localparam logic [HEADING_W-1:0] QUARTER_CDEG  = 16'd9000;
	localparam logic [HEADING_W-1:0] HALF_CDEG     = 16'd18000;
	localparam logic [HEADING_W-1:0] THREE_Q_CDEG  = 16'd27000;
	localparam logic [HEADING_W-1:0] FULL_CDEG     = 16'd36000;

	// Quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// CORDIC datapath
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 24;
	localparam int ATAN_IDX_W        = 5;
	localparam int ATAN_W            = 30;
	localparam int XY_W              = 18;
	localparam int Z_W               = 33;
	localparam int TRIG_W            = 16;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q15 = 18'sd19898;

	// Digit-serial multiplier
	localparam int DIGIT_W = 4;
	localparam int SCALE_B_W = 20;   // quadrant-mapped trig, sign room for +32768
	localparam int ANG_A_W   = 49;   // angle scale factor plus a zero sign bit
	localparam int ANG_B_W   = 16;   // residual angle, zero extended

	// Residual cdeg to radians * 2^30: r * ANGLE_MUL / 2^30, rounded up table constant
	localparam logic [63:0] ANGLE_MUL_64 =
		((64'd3373259426 << 30) + 64'd17999) / 64'd18000;
	localparam logic [ANG_A_W-2:0] ANGLE_MUL = ANGLE_MUL_64[ANG_A_W-2:0];

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_ROTATE,
		ST_SCALE,
		ST_WRITE
	} state_t;

	// Arctangent of 2^-i in radians scaled by 2^30
	function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/drpu_dsmul.sv -----
// Digit-serial signed multiplier: multiplier shifts out one digit per cycle, MSB first.
module drpu_dsmul #(
	parameter int A_W = 32,
	parameter int B_W = 20,
	parameter int D_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [A_W-1:0]     a,
	input  logic signed [B_W-1:0]     b,
	output logic                      done,
	output logic signed [A_W+B_W-1:0] prod
);

	localparam int ND   = B_W / D_W;
	localparam int CW   = $clog2(ND + 1);
	localparam int PW   = A_W + B_W;
	localparam int PPW  = A_W + D_W + 1;

	logic signed [A_W-1:0] a_q;
	logic [B_W-1:0]        b_q;
	logic signed [PW-1:0]  acc_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;

	logic                  first_digit;
	logic signed [D_W:0]   digit;
	logic signed [PPW-1:0] partial;

	// Top digit carries the sign, the rest are unsigned
	assign first_digit = (cnt_q == CW'(ND));
	assign digit   = signed'({first_digit & b_q[B_W-1], b_q[B_W-1 -: D_W]});
	assign partial = a_q * digit;

	// Operand registers and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			b_q   <= b_q << D_W;
			acc_q <= (acc_q <<< D_W) + PW'(partial);
		end
	end

	// Digit counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(ND);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- src/drpu_cordic.sv -----
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q1.15 cos and sin.
module drpu_cordic #(
	parameter int STAGES = drpu_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [drpu_pkg::Z_W-1:0]         z_in,
	output logic                                    done,
	output logic signed [drpu_pkg::TRIG_W-1:0]      cos_out,
	output logic signed [drpu_pkg::TRIG_W-1:0]      sin_out
);

	localparam int STAGES_EFF =
		(STAGES > drpu_pkg::ATAN_ENTRIES) ? drpu_pkg::ATAN_ENTRIES : STAGES;
	localparam int CW = $clog2(STAGES_EFF + 1);
	localparam int XW = drpu_pkg::XY_W;
	localparam int ZW = drpu_pkg::Z_W;
	localparam int TW = drpu_pkg::TRIG_W;
	localparam logic signed [XW-1:0] TRIG_MAX = XW'((1 << (TW - 1)) - 1);
	localparam logic signed [XW-1:0] TRIG_MIN = -XW'(1 << (TW - 1));

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [CW-1:0]        iter_q;
	logic                 busy_q;
	logic                 done_q;

	logic signed [XW-1:0]          xs, ys;
	logic [drpu_pkg::ATAN_W-1:0]   atan_u;
	logic signed [ZW-1:0]          atan_s;

	// Shifted operands and angle step for this iteration
	assign xs     = x_q >>> iter_q;
	assign ys     = y_q >>> iter_q;
	assign atan_u = drpu_pkg::atan_q30(drpu_pkg::ATAN_IDX_W'(iter_q));
	assign atan_s = signed'({{(ZW - drpu_pkg::ATAN_W){1'b0}}, atan_u});

	// Rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= drpu_pkg::CORDIC_GAIN_Q15;
			y_q <= '0;
			z_q <= z_in;
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_s;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_s;
			end
		end
	end

	// Iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				iter_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == CW'(STAGES_EFF - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Clamp to the Q1.15 range
	always_comb begin
		if (x_q > TRIG_MAX) begin
			cos_out = TRIG_MAX[TW-1:0];
		end else if (x_q < TRIG_MIN) begin
			cos_out = TRIG_MIN[TW-1:0];
		end else begin
			cos_out = x_q[TW-1:0];
		end
		if (y_q > TRIG_MAX) begin
			sin_out = TRIG_MAX[TW-1:0];
		end else if (y_q < TRIG_MIN) begin
			sin_out = TRIG_MIN[TW-1:0];
		end else begin
			sin_out = y_q[TW-1:0];
		end
	end

	assign done = done_q;

endmodule

// ----- src/dead_reckoning_position_update.sv -----
// Top level: heading/odometer ticks in, saturated x/y pose out.
//
//   channel | dir | handshake            | payload (low bit first)
//   --------+-----+----------------------+------------------------------------------
//   s_*     | in  | s_tvalid / s_tready  | tdata: heading_cdeg[15:0], odometer[47:16]
//   m_*     | out | m_tvalid / m_tready  | tdata: pos_x_out, pos_y_out, heading_out
//           |     |                      | tuser: saturated
//   cfg_*   | in  | cfg_we               | cfg_index 0 start_x, 1 start_y; cfg_data
//
// A tick passes from transfer in to result valid through a 4-bit digit-serial multiply
// for angle scaling (4 digits), the iterative CORDIC (one micro-rotation per cycle) and
// a second one for distance scaling (5 digits, x and y lanes in parallel).
// The next tick is taken in the cycle after the result enters the output register.
// Reset clears the pose and the previous odometer reading to zero.
// A stalled result holds in the output register; the next tick is processed behind it
// and waits in the final state until the output register frees.
module dead_reckoning_position_update #(
	parameter int CORDIC_STAGES = drpu_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// heading_cdeg[15:0], odometer[47:16]
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [47:0]                        s_tdata,
	// pos_x_out[31:0], pos_y_out[63:32], heading_out[79:64]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [79:0]                        m_tdata,
	// saturated[0]
	output logic [0:0]                         m_tuser,
	input  logic                               cfg_we,
	input  logic [drpu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [drpu_pkg::CFG_W-1:0]         cfg_data
);

	localparam int HW   = drpu_pkg::HEADING_W;
	localparam int PSW  = drpu_pkg::POS_W;
	localparam int OW   = drpu_pkg::ODO_W;
	localparam int RW   = drpu_pkg::RESID_W;
	localparam int TW   = drpu_pkg::TRIG_W;
	localparam int SBW  = drpu_pkg::SCALE_B_W;
	localparam int AAW  = drpu_pkg::ANG_A_W;
	localparam int ABW  = drpu_pkg::ANG_B_W;
	localparam int APW  = AAW + ABW;
	localparam int ASW  = 62;                  // significant bits of the angle product
	localparam int ZW   = drpu_pkg::Z_W;
	localparam int SPW  = OW + SBW;
	localparam int DXW  = SPW - 15;
	localparam int NPW  = DXW + 1;
	localparam logic [ASW-1:0]         ANG_ROUND  = ASW'(1) << 29;
	localparam logic signed [SPW-1:0]  STEP_ROUND = SPW'(16384);

	drpu_pkg::state_t state_q, state_d;

	logic                        accept;
	logic                        ang_done, cor_done, x_done, y_done;
	logic                        cor_start, scl_start, pos_load, out_load;

	logic [HW-1:0]               heading_q;
	logic [1:0]                  quad_q;
	logic signed [OW-1:0]        delta_q;
	logic [OW-1:0]               last_odo_q;
	logic signed [PSW-1:0]       pos_x_q, pos_y_q;
	logic                        sat_q;
	logic                        m_tvalid_q;
	logic [PSW-1:0]              out_x_q, out_y_q;
	logic [HW-1:0]               out_heading_q;
	logic                        out_sat_q;

	logic [HW-1:0]               h_in, h_red, h_off;
	logic [1:0]                  quad_in;
	logic [RW-1:0]               resid;
	logic [OW-1:0]               odo_in;

	logic signed [APW-1:0]       ang_prod;
	logic [ASW-1:0]              ang_sum;
	logic signed [ZW-1:0]        z_in;
	logic signed [TW-1:0]        cos_v, sin_v;
	logic signed [SBW-1:0]       cos_e, sin_e, trig_x, trig_y;
	logic signed [SPW-1:0]       x_prod, y_prod, x_rnd, y_rnd;
	logic signed [DXW-1:0]       dx, dy;
	logic signed [NPW-1:0]       nx, ny;
	logic                        ovx, ovy;
	logic signed [PSW-1:0]       sat_x, sat_y;

	assign accept = s_tvalid & s_tready;
	assign h_in   = s_tdata[15:0];
	assign odo_in = s_tdata[47:16];

	// Fold heading into a quadrant and a residual below a quarter turn
	always_comb begin
		h_red = (h_in >= drpu_pkg::FULL_CDEG) ? h_in - drpu_pkg::FULL_CDEG : h_in;
		if (h_red >= drpu_pkg::THREE_Q_CDEG) begin
			quad_in = drpu_pkg::QUAD_3;
			h_off   = drpu_pkg::THREE_Q_CDEG;
		end else if (h_red >= drpu_pkg::HALF_CDEG) begin
			quad_in = drpu_pkg::QUAD_2;
			h_off   = drpu_pkg::HALF_CDEG;
		end else if (h_red >= drpu_pkg::QUARTER_CDEG) begin
			quad_in = drpu_pkg::QUAD_1;
			h_off   = drpu_pkg::QUARTER_CDEG;
		end else begin
			quad_in = drpu_pkg::QUAD_0;
			h_off   = '0;
		end
		resid = RW'(h_red - h_off);
	end

	// Residual cdeg to radians * 2^30
	drpu_dsmul #(
		.A_W (AAW),
		.B_W (ABW),
		.D_W (drpu_pkg::DIGIT_W)
	) u_ang_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.a      (signed'({1'b0, drpu_pkg::ANGLE_MUL})),
		.b      (signed'({{(ABW - RW){1'b0}}, resid})),
		.done   (ang_done),
		.prod   (ang_prod)
	);

	assign ang_sum = ang_prod[ASW-1:0] + ANG_ROUND;
	assign z_in    = signed'({{(ZW - (ASW - 30)){1'b0}}, ang_sum[ASW-1:30]});

	drpu_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.z_in    (z_in),
		.done    (cor_done),
		.cos_out (cos_v),
		.sin_out (sin_v)
	);

	// Map residual sine and cosine back to the full-circle heading
	always_comb begin
		cos_e = SBW'(cos_v);
		sin_e = SBW'(sin_v);
		case (quad_q)
			drpu_pkg::QUAD_0: begin
				trig_x = sin_e;
				trig_y = cos_e;
			end
			drpu_pkg::QUAD_1: begin
				trig_x = cos_e;
				trig_y = -sin_e;
			end
			drpu_pkg::QUAD_2: begin
				trig_x = -sin_e;
				trig_y = -cos_e;
			end
			default: begin
				trig_x = -cos_e;
				trig_y = sin_e;
			end
		endcase
	end

	drpu_dsmul #(
		.A_W (OW),
		.B_W (SBW),
		.D_W (drpu_pkg::DIGIT_W)
	) u_x_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_start),
		.a      (delta_q),
		.b      (trig_x),
		.done   (x_done),
		.prod   (x_prod)
	);

	drpu_dsmul #(
		.A_W (OW),
		.B_W (SBW),
		.D_W (drpu_pkg::DIGIT_W)
	) u_y_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_start),
		.a      (delta_q),
		.b      (trig_y),
		.done   (y_done),
		.prod   (y_prod)
	);

	// Round the steps, add to the pose and clip at the 32-bit limits
	always_comb begin
		x_rnd = x_prod + STEP_ROUND;
		y_rnd = y_prod + STEP_ROUND;
		dx    = x_rnd[SPW-1:15];
		dy    = y_rnd[SPW-1:15];
		nx    = NPW'(pos_x_q) + NPW'(dx);
		ny    = NPW'(pos_y_q) + NPW'(dy);
		ovx   = (nx[NPW-1:PSW-1] != {(NPW - PSW + 1){nx[NPW-1]}});
		ovy   = (ny[NPW-1:PSW-1] != {(NPW - PSW + 1){ny[NPW-1]}});
		if (ovx) begin
			sat_x = nx[NPW-1] ? signed'({1'b1, {(PSW - 1){1'b0}}})
			                  : signed'({1'b0, {(PSW - 1){1'b1}}});
		end else begin
			sat_x = nx[PSW-1:0];
		end
		if (ovy) begin
			sat_y = ny[NPW-1] ? signed'({1'b1, {(PSW - 1){1'b0}}})
			                  : signed'({1'b0, {(PSW - 1){1'b1}}});
		end else begin
			sat_y = ny[PSW-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			drpu_pkg::ST_IDLE:   if (accept)   state_d = drpu_pkg::ST_ANGLE;
			drpu_pkg::ST_ANGLE:  if (ang_done) state_d = drpu_pkg::ST_ROTATE;
			drpu_pkg::ST_ROTATE: if (cor_done) state_d = drpu_pkg::ST_SCALE;
			drpu_pkg::ST_SCALE:  if (x_done)   state_d = drpu_pkg::ST_WRITE;
			drpu_pkg::ST_WRITE:  if (out_load) state_d = drpu_pkg::ST_IDLE;
			default:                           state_d = drpu_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready  = (state_q == drpu_pkg::ST_IDLE);
		cor_start = (state_q == drpu_pkg::ST_ANGLE) & ang_done;
		scl_start = (state_q == drpu_pkg::ST_ROTATE) & cor_done;
		pos_load  = (state_q == drpu_pkg::ST_SCALE) & x_done;
		out_load  = (state_q == drpu_pkg::ST_WRITE) & (~m_tvalid_q | m_tready);
	end

	// State, pose, previous odometer reading and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= drpu_pkg::ST_IDLE;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			last_odo_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_odo_q <= odo_in;
			end
			if (cfg_we) begin
				case (cfg_index)
					drpu_pkg::REG_START_X: pos_x_q <= signed'(cfg_data);
					drpu_pkg::REG_START_Y: pos_y_q <= signed'(cfg_data);
					default: ;
				endcase
			end else if (pos_load) begin
				pos_x_q <= sat_x;
				pos_y_q <= sat_y;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Per-tick payload
	always_ff @(posedge clk) begin
		if (accept) begin
			heading_q <= h_in;
			quad_q    <= quad_in;
			delta_q   <= signed'(odo_in - last_odo_q);
		end
		if (pos_load) begin
			sat_q <= ovx | ovy;
		end
		if (out_load) begin
			out_x_q       <= pos_x_q;
			out_y_q       <= pos_y_q;
			out_heading_q <= heading_q;
			out_sat_q     <= sat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_heading_q, out_y_q, out_x_q};
	assign m_tuser  = out_sat_q;

	// A transfer in always starts the angle multiply
	a_accept_to_angle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == drpu_pkg::ST_ANGLE))
		else $error("transfer in did not start angle scaling");

	// Angle product completes only while waiting for it
	a_ang_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		ang_done |-> (state_q == drpu_pkg::ST_ANGLE))
		else $error("angle multiply finished outside its state");

	// CORDIC completes only while rotating
	a_cor_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == drpu_pkg::ST_ROTATE))
		else $error("CORDIC finished outside its state");

	// x and y lanes run in lockstep
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		x_done == y_done)
		else $error("x and y multiply lanes out of step");

	// A loaded result is presented on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("loaded result not presented");

endmodule
